@@ hw/rtl/rpn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack calculator
// Operation and status codes, stack sizing and the beat payload structs.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 128;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Operation codes
  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_PEEK = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_FEW_OPS  = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Q16.16 range limits
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic [7:0]         depth;
  } rsp_t;

endpackage

@@ hw/rtl/rpn_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_div: iterative Q16.16 divider
// Computes (a * 65536) / b truncated toward zero and saturated to 32 bits,
// one quotient bit per cycle, with an early overflow check.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic [31:0] mag_a;
  logic [31:0] mag_d;
  logic        early_ovf;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] sh;
  logic [31:0] dvs;
  logic        neg;
  logic        ovf;

  logic [32:0] rem_ext;
  logic        qbit;

  // Take magnitudes; the quotient overflows 32 bits when |a| >= |b| << 16
  assign mag_a     = dividend[31] ? 32'(-dividend) : 32'(dividend);
  assign mag_d     = divisor[31]  ? 32'(-divisor)  : 32'(divisor);
  assign early_ovf = {16'b0, mag_a} >= {mag_d, 16'b0};

  // Trial subtract for one restoring step
  assign rem_ext = {rem, sh[31]};
  assign qbit    = rem_ext >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[31] ^ divisor[31];
      ovf <= early_ovf;
      dvs <= mag_d;
      rem <= {16'b0, mag_a[31:16]};
      sh  <= {mag_a[15:0], 16'b0};
    end else if (busy) begin
      rem <= qbit ? 32'(rem_ext - {1'b0, dvs}) : rem_ext[31:0];
      sh  <= {sh[30:0], qbit};
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (neg) begin
      if (ovf || (sh > 32'h8000_0000)) begin
        quotient = rpn_pkg::Q_MIN;
      end else begin
        quotient = 32'(-sh);
      end
    end else begin
      if (ovf || sh[31]) begin
        quotient = rpn_pkg::Q_MAX;
      end else begin
        quotient = sh;
      end
    end
  end

endmodule

@@ hw/rtl/rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse Polish calculator on signed Q16.16 values
// Stack held in a synchronous RAM; top entry mirrored in a register.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one operation per beat:
//   push, add, subtract, multiply, divide or peek. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one beat per operation with status, new
//   top value and depth.
//   One operation is in flight at a time. Push, peek, add, subtract and all
//   error cases respond from the execute state, multiply after a product
//   register, then shift and saturate, and divide once the one-bit-per-cycle
//   divider is done. The first operand (the entry under the top) is
//   read from the stack RAM at accept; the second is the top register.
//   The response sits in an output register; while rsp_stall is high it holds
//   and a new command is taken only once that beat leaves. Reset empties the
//   stack (entry count cleared, RAM contents are not touched) and drops any
//   pending response.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rpn_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rpn_pkg::rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  localparam int IDX_W = rpn_pkg::IDX_W;
  localparam int CNT_W = rpn_pkg::CNT_W;

  logic [1:0]             state;
  rpn_pkg::cmd_t          cmd_q;
  logic [CNT_W-1:0]       count;
  logic signed [31:0]     top;
  logic signed [31:0]     rd_data;
  logic signed [63:0]     prod;

  logic signed [31:0]     mem [rpn_pkg::STACK_DEPTH];

  logic                   accept;
  logic                   is_binary;
  logic                   push_ok;
  logic                   few_ops;
  logic                   div_zero;
  logic                   op_done;
  logic signed [31:0]     op_res;
  logic signed [31:0]     first;
  logic signed [31:0]     second;
  logic signed [32:0]     sum;
  logic signed [32:0]     diff;
  logic signed [31:0]     sum_sat;
  logic signed [31:0]     diff_sat;
  logic signed [31:0]     mul_sat;
  logic signed [31:0]     top_out;
  logic [CNT_W-1:0]       count_dec;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic signed [31:0]     wr_data;
  logic [IDX_W-1:0]       rd_idx;
  logic                   div_start;
  logic                   div_done;
  logic signed [31:0]     div_q;

  // Take a command only when idle and the response register is free
  assign cmd_stall = !((state == S_IDLE) && (!rsp_valid || !rsp_stall));
  assign accept    = cmd_valid && !cmd_stall;

  // Operands: second is the register copy of the top, first comes from RAM
  assign second    = top;
  assign first     = rd_data;
  assign count_dec = count - CNT_W'(1);
  assign rd_idx    = IDX_W'(count - CNT_W'(2));

  assign is_binary = (cmd_q.mode >= rpn_pkg::MODE_ADD) && (cmd_q.mode <= rpn_pkg::MODE_DIV);
  assign few_ops   = count < CNT_W'(2);
  assign div_zero  = (cmd_q.mode == rpn_pkg::MODE_DIV) && (second == 32'sd0);
  assign push_ok   = (state == S_EXEC) && (cmd_q.mode == rpn_pkg::MODE_PUSH) &&
                     (count < CNT_W'(rpn_pkg::STACK_DEPTH));

  // Saturating add and subtract
  assign sum      = 33'(first) + 33'(second);
  assign diff     = 33'(first) - 33'(second);
  assign sum_sat  = (sum[32] != sum[31]) ? (sum[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                                         : sum[31:0];
  assign diff_sat = (diff[32] != diff[31]) ? (diff[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX)
                                           : diff[31:0];

  // Shift the product down by 16 (floor) and saturate
  assign mul_sat = ((&prod[63:47]) || !(|prod[63:47])) ? prod[47:16]
                 : (prod[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX);

  assign top_out = (count == '0) ? 32'sd0 : top;

  // Select the finishing result of a binary operation
  always_comb begin
    op_done   = 1'b0;
    op_res    = sum_sat;
    div_start = 1'b0;
    unique case (state)
      S_EXEC: begin
        if (is_binary && !few_ops && !div_zero) begin
          if (cmd_q.mode == rpn_pkg::MODE_ADD) begin
            op_done = 1'b1;
            op_res  = sum_sat;
          end else if (cmd_q.mode == rpn_pkg::MODE_SUB) begin
            op_done = 1'b1;
            op_res  = diff_sat;
          end else if (cmd_q.mode == rpn_pkg::MODE_DIV) begin
            div_start = 1'b1;
          end
        end
      end
      S_MUL: begin
        op_done = 1'b1;
        op_res  = mul_sat;
      end
      S_DIV: begin
        op_done = div_done;
        op_res  = div_q;
      end
      default: begin
        op_done = 1'b0;
      end
    endcase
  end

  // RAM write port: push at count, result of an operation at count - 2
  assign wr_en   = push_ok || op_done;
  assign wr_idx  = push_ok ? IDX_W'(count) : rd_idx;
  assign wr_data = push_ok ? cmd_q.value : op_res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (accept) begin
      rd_data <= mem[rd_idx];
    end
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (first),
    .divisor  (second),
    .done     (div_done),
    .quotient (div_q)
  );

  // Hold the command and form the product
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (state == S_EXEC) begin
      prod <= 64'(first) * 64'(second);
    end
  end

  // Sequence one operation and load the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          priority if (cmd_q.mode == rpn_pkg::MODE_PUSH) begin
            rsp_valid <= 1'b1;
            if (push_ok) begin
              count         <= count + CNT_W'(1);
              rsp.status    <= rpn_pkg::ST_OK;
              rsp.top_value <= cmd_q.value;
              rsp.depth     <= 8'(count + CNT_W'(1));
            end else begin
              rsp.status    <= rpn_pkg::ST_OVERFLOW;
              rsp.top_value <= top_out;
              rsp.depth     <= 8'(count);
            end
          end else if (is_binary) begin
            if (few_ops || div_zero) begin
              rsp_valid     <= 1'b1;
              rsp.status    <= few_ops ? rpn_pkg::ST_FEW_OPS : rpn_pkg::ST_DIV_ZERO;
              rsp.top_value <= top_out;
              rsp.depth     <= 8'(count);
            end else if (cmd_q.mode == rpn_pkg::MODE_MUL) begin
              state <= S_MUL;
            end else if (cmd_q.mode == rpn_pkg::MODE_DIV) begin
              state <= S_DIV;
            end
          end else begin
            rsp_valid     <= 1'b1;
            rsp.status    <= (count == '0) ? rpn_pkg::ST_EMPTY : rpn_pkg::ST_OK;
            rsp.top_value <= top_out;
            rsp.depth     <= 8'(count);
          end
        end
        S_MUL: begin
          state <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Pop one entry and report the new top
      if (op_done) begin
        count         <= count_dec;
        rsp_valid     <= 1'b1;
        rsp.status    <= rpn_pkg::ST_OK;
        rsp.top_value <= op_res;
        rsp.depth     <= 8'(count_dec);
      end
    end
  end

  // Mirror the top entry
  always_ff @(posedge clk) begin
    if (push_ok) begin
      top <= cmd_q.value;
    end else if (op_done) begin
      top <= op_res;
    end else if (state == S_EXEC && is_binary && !few_ops && !div_zero) begin
      top <= top;
    end
  end

endmodule

@@ tb/rpn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_checker: scoreboard for the RPN stack calculator
// Watches both beat channels, keeps its own stack image to work out the
// response to every accepted command, and compares each response beat field
// by field against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module rpn_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  rpn_pkg::cmd_t cmd,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  rpn_pkg::rsp_t rsp,
  output int unsigned   error_count,
  output int unsigned   answers_due,
  output int unsigned   beats_checked,
  output int unsigned   overflow_hits,
  output int unsigned   few_ops_hits,
  output int unsigned   div_zero_hits,
  output int unsigned   empty_hits
);

  // Stack image and outstanding answers
  logic signed [31:0] stack_img [rpn_pkg::STACK_DEPTH];
  int unsigned        stack_level = 0;
  rpn_pkg::rsp_t      answer_q [$];

  // Running tallies, copied to the outputs once per clock
  int unsigned fails   = 0;
  int unsigned checked = 0;
  int unsigned n_ovf   = 0;
  int unsigned n_few   = 0;
  int unsigned n_dz    = 0;
  int unsigned n_empty = 0;

  // Clamp a wide intermediate to the Q16.16 range
  function automatic logic signed [31:0] clamp_q(input longint x);
    if (x > longint'(rpn_pkg::Q_MAX)) return rpn_pkg::Q_MAX;
    if (x < longint'(rpn_pkg::Q_MIN)) return rpn_pkg::Q_MIN;
    return x[31:0];
  endfunction

  // Apply one command to the stack image and build the response it causes
  task automatic rpn_eval(input rpn_pkg::cmd_t c, output rpn_pkg::rsp_t r);
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic signed [31:0] res;
    logic [2:0]         st;
    st  = rpn_pkg::ST_OK;
    res = '0;
    case (c.mode)
      rpn_pkg::MODE_PUSH: begin
        if (stack_level >= rpn_pkg::STACK_DEPTH) begin
          st = rpn_pkg::ST_OVERFLOW;
        end else begin
          stack_img[stack_level] = c.value;
          stack_level++;
        end
      end
      rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL, rpn_pkg::MODE_DIV: begin
        if (stack_level < 2) begin
          st = rpn_pkg::ST_FEW_OPS;
        end else begin
          rhs = stack_img[stack_level - 1];
          lhs = stack_img[stack_level - 2];
          if (c.mode == rpn_pkg::MODE_DIV && rhs == 0) begin
            st = rpn_pkg::ST_DIV_ZERO;
          end else begin
            case (c.mode)
              rpn_pkg::MODE_ADD: res = clamp_q(longint'(lhs) + longint'(rhs));
              rpn_pkg::MODE_SUB: res = clamp_q(longint'(lhs) - longint'(rhs));
              // arithmetic shift floors the product
              rpn_pkg::MODE_MUL: res = clamp_q((longint'(lhs) * longint'(rhs)) >>> 16);
              // signed division truncates toward zero
              default:  res = clamp_q((longint'(lhs) <<< 16) / longint'(rhs));
            endcase
            stack_level--;
            stack_img[stack_level - 1] = res;
          end
        end
      end
      // peek and the two spare codes only report
      default: begin
        if (stack_level == 0) st = rpn_pkg::ST_EMPTY;
      end
    endcase
    r.status    = st;
    r.top_value = (stack_level == 0) ? 32'sd0 : stack_img[stack_level - 1];
    r.depth     = 8'(stack_level);
  endtask

  // Count a failure; print only the first few
  task automatic flag_field(input string field, input longint exp_v, input longint act_v);
    fails++;
    if (fails <= 10)
      $display("[%0t] mismatch on %s in response %0d: expected %0d, got %0d",
               $realtime, field, checked, exp_v, act_v);
  endtask

  // Predict on command beats, compare on response beats
  always @(posedge clk) begin
    rpn_pkg::rsp_t want;
    rpn_pkg::rsp_t got;
    if (rst) begin
      stack_level = 0;
      answer_q.delete();
    end else begin
      // retire the response first: it always belongs to an older command
      if (rsp_valid && !rsp_stall) begin
        checked++;
        got = rsp;
        if (answer_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] response with nothing awaited: status %0d top %0d depth %0d",
                     $realtime, got.status, got.top_value, got.depth);
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status)
            flag_field("status", want.status, got.status);
          if (got.top_value !== want.top_value)
            flag_field("top_value", want.top_value, got.top_value);
          if (got.depth !== want.depth)
            flag_field("depth", want.depth, got.depth);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        rpn_eval(cmd, want);
        case (want.status)
          rpn_pkg::ST_OVERFLOW: n_ovf++;
          rpn_pkg::ST_FEW_OPS:  n_few++;
          rpn_pkg::ST_DIV_ZERO: n_dz++;
          rpn_pkg::ST_EMPTY:    n_empty++;
          default:     ;
        endcase
        answer_q.push_back(want);
      end
    end
    error_count   <= fails;
    answers_due   <= answer_q.size();
    beats_checked <= checked;
    overflow_hits <= n_ovf;
    few_ops_hits  <= n_few;
    div_zero_hits <= n_dz;
    empty_hits    <= n_empty;
  end

endmodule

@@ tb/tb_rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator: stimulus and verdict for the RPN stack calculator
// Sends a directed opening of edge cases, then random expression sequences,
// stack fills and drains and loose noise, under four idle/stall mixes; the
// checker instance scores every response beat.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator;

  // Spare operation codes, which behave as peek
  localparam logic [2:0]  MODE_SPARE6  = 3'd6;
  localparam logic [2:0]  MODE_SPARE7  = 3'd7;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  rpn_pkg::cmd_t cmd       = '0;
  logic          rsp_stall = 1'b0;
  logic          cmd_stall;
  logic          rsp_valid;
  rpn_pkg::rsp_t rsp;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned ops_sent  = 0;
  int unsigned cycle_n   = 0;

  int unsigned error_count;
  int unsigned answers_due;
  int unsigned beats_checked;
  int unsigned overflow_hits;
  int unsigned few_ops_hits;
  int unsigned div_zero_hits;
  int unsigned empty_hits;

  rpn_stack_calculator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  rpn_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .error_count   (error_count),
    .answers_due   (answers_due),
    .beats_checked (beats_checked),
    .overflow_hits (overflow_hits),
    .few_ops_hits  (few_ops_hits),
    .div_zero_hits (div_zero_hits),
    .empty_hits    (empty_hits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the response side at the current phase rate
  always @(posedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses still due", cycle_n, answers_due);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Send one command beat, idling first at the current phase rate
  task automatic send_op(input logic [2:0] m, input logic signed [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    cmd.mode   <= m;
    cmd.value  <= v;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    ops_sent++;
  endtask

  // Hold the sender until every response is back
  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
  endtask

  // Operand mix leaning on range limits and unit values
  function automatic logic signed [31:0] pick_q();
    case ($urandom_range(9))
      0:       return rpn_pkg::Q_MAX;
      1:       return rpn_pkg::Q_MIN;
      2:       return 32'sd0;
      3:       return 32'sh0001_0000;
      4:       return -32'sh0001_0000;
      5, 6:    return 32'($urandom_range(32'h3_FFFF)) - 32'sh0002_0000;
      default: return 32'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] bin_op();
    case ($urandom_range(3))
      0:       return rpn_pkg::MODE_ADD;
      1:       return rpn_pkg::MODE_SUB;
      2:       return rpn_pkg::MODE_MUL;
      default: return rpn_pkg::MODE_DIV;
    endcase
  endfunction

  // Push past full, then fold down past a single entry
  task automatic fill_and_drain();
    repeat (rpn_pkg::STACK_DEPTH + 6) send_op(rpn_pkg::MODE_PUSH, pick_q());
    repeat (rpn_pkg::STACK_DEPTH + 6) send_op(bin_op(), 32'($urandom()));
  endtask

  // Random traffic: mostly well-formed expressions, some noise, fills and drains
  task automatic run_mix(input int unsigned target);
    int unsigned r;
    int unsigned k;
    while (ops_sent < target) begin
      r = $urandom_range(19);
      if (r < 12) begin
        k = $urandom_range(2, 6);
        repeat (k) send_op(rpn_pkg::MODE_PUSH, pick_q());
        repeat (k - 1) send_op(bin_op(), 32'($urandom()));
        send_op(rpn_pkg::MODE_PEEK, 32'($urandom()));
      end else if (r < 15) begin
        send_op(3'($urandom_range(7)), 32'($urandom()));
      end else if (r < 17) begin
        repeat ($urandom_range(3, 12)) send_op(bin_op(), 32'($urandom()));
      end else begin
        repeat ($urandom_range(10, 40)) send_op(rpn_pkg::MODE_PUSH, pick_q());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, no idling
    send_op(rpn_pkg::MODE_PEEK, 32'sd0);              // peek on an empty stack
    send_op(rpn_pkg::MODE_ADD, 32'sd0);               // too few operands, none held
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MAX);
    send_op(MODE_SPARE6, 32'sd0);                     // spare code acts as peek
    send_op(rpn_pkg::MODE_SUB, 32'sd0);               // too few operands, one held
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MAX);
    send_op(rpn_pkg::MODE_ADD, 32'sd0);               // sum clamps high
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MIN);
    send_op(rpn_pkg::MODE_PUSH, 32'sd1);
    send_op(rpn_pkg::MODE_SUB, 32'sd0);               // difference clamps low
    send_op(rpn_pkg::MODE_PUSH, 32'sd0);
    send_op(rpn_pkg::MODE_DIV, 32'sd0);               // divide by zero keeps both
    send_op(MODE_SPARE7, 32'sd0);
    send_op(rpn_pkg::MODE_MUL, 32'sd0);
    send_op(rpn_pkg::MODE_PUSH, 32'sh0001_8000);
    send_op(rpn_pkg::MODE_PUSH, -32'sd3);
    send_op(rpn_pkg::MODE_MUL, 32'sd0);               // negative product floors
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MIN);
    send_op(rpn_pkg::MODE_PUSH, -32'sh0001_0000);
    send_op(rpn_pkg::MODE_DIV, 32'sd0);               // quotient clamps high
    send_op(rpn_pkg::MODE_PUSH, -32'sd1);
    send_op(rpn_pkg::MODE_PUSH, 32'sd3);
    send_op(rpn_pkg::MODE_DIV, 32'sd0);               // quotient truncates toward zero
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MAX);
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MAX);
    send_op(rpn_pkg::MODE_MUL, 32'sd0);               // product clamps high
    send_op(rpn_pkg::MODE_PUSH, rpn_pkg::Q_MIN);
    send_op(rpn_pkg::MODE_MUL, 32'sd0);               // product clamps low

    // Full-rate random traffic, including one full stack
    fill_and_drain();
    run_mix(400);
    wait_quiet();

    // Sparse sender
    idle_pct = 86;
    run_mix(620);
    wait_quiet();

    // Heavy receiver back-pressure
    idle_pct  = 0;
    stall_pct = 86;
    run_mix(840);
    wait_quiet();

    // Light idling on both sides, another full stack
    idle_pct  = 16;
    stall_pct = 16;
    fill_and_drain();
    run_mix(1100);
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands, %0d responses checked, across four idle/stall mixes.",
             ops_sent, beats_checked);
    $display("Error responses seen: %0d full stack, %0d too few, %0d div by zero, %0d empty.",
             overflow_hits, few_ops_hits, div_zero_hits, empty_hits);
    if (error_count == 0 && answers_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
